@@ hw/rtl/range_count_at_least_defines.svh @@
// ----------------------------------------------------------------------------
// range_count_at_least_defines.svh
// Assertion macros for the range count block; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef RANGE_COUNT_AT_LEAST_DEFINES_SVH
`define RANGE_COUNT_AT_LEAST_DEFINES_SVH

`ifndef SYNTHESIS
`define RCAL_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RCAL_NEVER(name, clk, rstn, expr, msg) \
    `RCAL_ASSERT(name, clk, rstn, !(expr), msg)
`else
`define RCAL_ASSERT(name, clk, rstn, prop, msg)
`define RCAL_NEVER(name, clk, rstn, expr, msg)
`endif

`endif

@@ hw/rtl/rcal_pkg.sv @@
// ----------------------------------------------------------------------------
// rcal_pkg
// Shared widths, defaults and operation codes of the range count block.
// ----------------------------------------------------------------------------
package rcal_pkg;

    localparam int MAX_ELEMS_DEF   = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [COUNT_W-1:0] ELEM_COUNT_RESET = 11'd1024;

endpackage

@@ hw/rtl/range_count_at_least.sv @@
// ----------------------------------------------------------------------------
// range_count_at_least
// Merge sort tree that counts array elements at or above a threshold.
// ----------------------------------------------------------------------------
// A load writes the element store as it is accepted. A build copies the array
// into level 0 and then merges each level from the one below, reading both
// halves through the two read ports of the level memory in S_MREAD and writing
// the chosen element in S_MWRITE. A query clamps the range in S_QCLAMP, then
// splits it into aligned segments; each segment is chosen in S_QPICK, one level
// at a time, and searched by binary search in S_QREAD and S_QCMP against the
// registered memory read, and S_DONE hands the count to the output register.
// At 1024 elements the worst case, a range such as 1 to 1022, breaks into
// eighteen segments. One transaction is processed at a time; a finished count
// waits in the output register while the next transaction is taken, and a
// query that finishes while that register is still stalled waits until it
// empties.
module range_count_at_least
    import rcal_pkg::*;
#(
    parameter int MAX_ELEMS   = MAX_ELEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FUNC_W-1:0]      func,
    input  logic [INDEX_W-1:0]     elem_index,
    input  logic [VALUE_WIDTH-1:0] elem_value,
    input  logic [INDEX_W-1:0]     range_low,
    input  logic [INDEX_W-1:0]     range_high,
    input  logic [VALUE_WIDTH-1:0] threshold,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COUNT_W-1:0]     match_count,
    input  logic                   cfg_wr_en,
    input  logic [COUNT_W-1:0]     cfg_wr_data
);

`include "range_count_at_least_defines.svh"

    localparam int AW    = $clog2(MAX_ELEMS);
    localparam int NLEV  = $clog2(MAX_ELEMS + 1);
    localparam int DEPTH = NLEV * MAX_ELEMS;
    localparam int SAW   = $clog2(DEPTH);

    logic                   em_we;
    logic [AW-1:0]          em_waddr;
    logic [VALUE_WIDTH-1:0] em_wdata;
    logic [AW-1:0]          em_raddr;
    logic [VALUE_WIDTH-1:0] em_rdata;
    logic                   lm_we;
    logic [SAW-1:0]         lm_waddr;
    logic [VALUE_WIDTH-1:0] lm_wdata;
    logic [SAW-1:0]         lm_raddr_a;
    logic [VALUE_WIDTH-1:0] lm_rdata_a;
    logic [SAW-1:0]         lm_raddr_b;
    logic [VALUE_WIDTH-1:0] lm_rdata_b;

    rcal_elem_mem #(
        .MAX_ELEMS   (MAX_ELEMS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_elem_mem (
        .clk   (clk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (em_wdata),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    rcal_level_mem #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .SAW         (SAW)
    ) u_level_mem (
        .clk     (clk),
        .we      (lm_we),
        .waddr   (lm_waddr),
        .wdata   (lm_wdata),
        .raddr_a (lm_raddr_a),
        .rdata_a (lm_rdata_a),
        .raddr_b (lm_raddr_b),
        .rdata_b (lm_rdata_b)
    );

    rcal_seq #(
        .MAX_ELEMS   (MAX_ELEMS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .NLEV        (NLEV),
        .SAW         (SAW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .elem_index  (elem_index),
        .elem_value  (elem_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .threshold   (threshold),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .match_count (match_count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .em_we       (em_we),
        .em_waddr    (em_waddr),
        .em_wdata    (em_wdata),
        .em_raddr    (em_raddr),
        .em_rdata    (em_rdata),
        .lm_we       (lm_we),
        .lm_waddr    (lm_waddr),
        .lm_wdata    (lm_wdata),
        .lm_raddr_a  (lm_raddr_a),
        .lm_rdata_a  (lm_rdata_a),
        .lm_raddr_b  (lm_raddr_b),
        .lm_rdata_b  (lm_rdata_b)
    );

    // A build or a query occupies the sequencer for at least the next cycle.
    `RCAL_ASSERT(a_busy_after_query, clk, rst_n,
        in_valid && !in_stall && func == FUNC_QUERY |=> in_stall,
        "query accepted but sequencer not busy")
    `RCAL_ASSERT(a_busy_after_build, clk, rst_n,
        in_valid && !in_stall && func == FUNC_BUILD |=> in_stall,
        "build accepted but sequencer not busy")
    // A count never exceeds the array size, MAX_ELEMS.
    `RCAL_NEVER(a_count_range, clk, rst_n,
        out_valid && (match_count > MAX_ELEMS),
        "match count above array size")
    // A load never produces a result.
    `RCAL_NEVER(a_load_no_result, clk, rst_n,
        $past(!out_valid && in_valid && !in_stall && func == FUNC_LOAD) && out_valid,
        "load produced a result")

endmodule

@@ hw/rtl/rcal_elem_mem.sv @@
// ----------------------------------------------------------------------------
// rcal_elem_mem
// Element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rcal_elem_mem
    import rcal_pkg::*;
#(
    parameter int MAX_ELEMS   = MAX_ELEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(MAX_ELEMS)
)
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [AW-1:0]          waddr,
    input  logic [VALUE_WIDTH-1:0] wdata,
    input  logic [AW-1:0]          raddr,
    output logic [VALUE_WIDTH-1:0] rdata
);

    logic [VALUE_WIDTH-1:0] mem [MAX_ELEMS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/rcal_level_mem.sv @@
// ----------------------------------------------------------------------------
// rcal_level_mem
// Sorted level store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rcal_level_mem
    import rcal_pkg::*;
#(
    parameter int DEPTH       = MAX_ELEMS_DEF * 11,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int SAW         = $clog2(DEPTH)
)
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [SAW-1:0]         waddr,
    input  logic [VALUE_WIDTH-1:0] wdata,
    input  logic [SAW-1:0]         raddr_a,
    output logic [VALUE_WIDTH-1:0] rdata_a,
    input  logic [SAW-1:0]         raddr_b,
    output logic [VALUE_WIDTH-1:0] rdata_b
);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hw/rtl/rcal_seq.sv @@
// ----------------------------------------------------------------------------
// rcal_seq
// Sequencer: loads, level build by pairwise merging, and query search.
// ----------------------------------------------------------------------------
module rcal_seq
    import rcal_pkg::*;
#(
    parameter int MAX_ELEMS   = MAX_ELEMS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(MAX_ELEMS),
    parameter int NLEV        = $clog2(MAX_ELEMS + 1),
    parameter int SAW         = $clog2(NLEV * MAX_ELEMS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FUNC_W-1:0]      func,
    input  logic [INDEX_W-1:0]     elem_index,
    input  logic [VALUE_WIDTH-1:0] elem_value,
    input  logic [INDEX_W-1:0]     range_low,
    input  logic [INDEX_W-1:0]     range_high,
    input  logic [VALUE_WIDTH-1:0] threshold,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COUNT_W-1:0]     match_count,
    input  logic                   cfg_wr_en,
    input  logic [COUNT_W-1:0]     cfg_wr_data,
    output logic                   em_we,
    output logic [AW-1:0]          em_waddr,
    output logic [VALUE_WIDTH-1:0] em_wdata,
    output logic [AW-1:0]          em_raddr,
    input  logic [VALUE_WIDTH-1:0] em_rdata,
    output logic                   lm_we,
    output logic [SAW-1:0]         lm_waddr,
    output logic [VALUE_WIDTH-1:0] lm_wdata,
    output logic [SAW-1:0]         lm_raddr_a,
    input  logic [VALUE_WIDTH-1:0] lm_rdata_a,
    output logic [SAW-1:0]         lm_raddr_b,
    input  logic [VALUE_WIDTH-1:0] lm_rdata_b
);

    localparam int PW = $clog2(MAX_ELEMS + 1) + 1;
    localparam int XW = (PW > COUNT_W + 1) ? PW : COUNT_W + 1;
    localparam int LW = $clog2(NLEV);

    localparam logic [XW-1:0]  M_X   = XW'(MAX_ELEMS);
    localparam logic [SAW-1:0] M_S   = SAW'(MAX_ELEMS);
    localparam logic [LW-1:0]  LV_TOP = LW'(NLEV - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_COPY,
        S_MREAD,
        S_MWRITE,
        S_QCLAMP,
        S_QPICK,
        S_QREAD,
        S_QCMP,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_W-1:0]     elem_count_reg, elem_count_next;
    logic [LW-1:0]          lv_reg, lv_next;
    logic [SAW-1:0]         base_reg, base_next;
    logic [SAW-1:0]         src_base_reg, src_base_next;
    logic [SAW-1:0]         dst_base_reg, dst_base_next;
    logic [XW-1:0]          pos_reg, pos_next;
    logic [XW-1:0]          end_reg, end_next;
    logic [XW-1:0]          a_reg, a_next;
    logic [XW-1:0]          b_reg, b_next;
    logic [XW-1:0]          mid_reg, mid_next;
    logic [XW-1:0]          seg_end_reg, seg_end_next;
    logic [XW-1:0]          start_reg, start_next;
    logic [XW-1:0]          seg_reg, seg_next;
    logic [XW-1:0]          wpos_reg, wpos_next;
    logic [XW-1:0]          blo_reg, blo_next;
    logic [XW-1:0]          bhi_reg, bhi_next;
    logic [XW-1:0]          bmid_reg, bmid_next;
    logic [XW-1:0]          total_reg, total_next;
    logic [XW-1:0]          copy_idx_reg, copy_idx_next;
    logic                   copy_wv_reg, copy_wv_next;
    logic [AW-1:0]          copy_wa_reg, copy_wa_next;
    logic [INDEX_W-1:0]     lo_reg, lo_next;
    logic [INDEX_W-1:0]     hi_reg, hi_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    logic          accept;
    logic          take_a;
    logic [XW-1:0] a_adv, b_adv, next_start, half, seg_end_c, mid_c;
    logic [XW-1:0] s2, len, qmid, cnt, hi1, endv;
    logic [LW:0]   lv_up;

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign out_valid   = out_valid_reg;
    assign match_count = count_reg;

    always_comb
    begin
        state_next      = state_reg;
        elem_count_next = elem_count_reg;
        lv_next         = lv_reg;
        base_next       = base_reg;
        src_base_next   = src_base_reg;
        dst_base_next   = dst_base_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        mid_next        = mid_reg;
        seg_end_next    = seg_end_reg;
        start_next      = start_reg;
        seg_next        = seg_reg;
        wpos_next       = wpos_reg;
        blo_next        = blo_reg;
        bhi_next        = bhi_reg;
        bmid_next       = bmid_reg;
        total_next      = total_reg;
        copy_idx_next   = copy_idx_reg;
        copy_wv_next    = 1'b0;
        copy_wa_next    = copy_idx_reg[AW-1:0];
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        key_next        = key_reg;
        out_valid_next  = out_valid_reg && out_stall;
        count_next      = count_reg;

        em_we      = 1'b0;
        em_waddr   = AW'(elem_index);
        em_wdata   = elem_value;
        em_raddr   = copy_idx_reg[AW-1:0];
        lm_we      = copy_wv_reg;
        lm_waddr   = SAW'(copy_wa_reg);
        lm_wdata   = em_rdata;
        lm_raddr_a = SAW'(src_base_reg + SAW'(a_reg));
        lm_raddr_b = SAW'(src_base_reg + SAW'(b_reg));

        take_a     = (a_reg < mid_reg)
                     && ((b_reg >= seg_end_reg) || ($signed(lm_rdata_a) < $signed(lm_rdata_b)));
        a_adv      = take_a ? a_reg + 1'b1 : a_reg;
        b_adv      = take_a ? b_reg : b_reg + 1'b1;
        next_start = start_reg + seg_reg;
        half       = seg_reg;
        seg_end_c  = '0;
        mid_c      = '0;
        lv_up      = {1'b0, lv_reg} + 1'b1;
        s2         = XW'(1) << lv_up;
        len        = XW'(1) << lv_reg;
        qmid       = blo_reg + ((bhi_reg - blo_reg) >> 1);
        cnt        = (XW'(elem_count_reg) > M_X) ? M_X : XW'(elem_count_reg);
        hi1        = XW'(hi_reg) + 1'b1;
        endv       = (hi1 < cnt) ? hi1 : cnt;

        if (cfg_wr_en)
        begin
            elem_count_next = cfg_wr_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_LOAD:
                        begin
                            em_we = (XW'(elem_index) < M_X);
                        end
                        FUNC_BUILD:
                        begin
                            copy_idx_next = '0;
                            state_next    = S_COPY;
                        end
                        FUNC_QUERY:
                        begin
                            lo_next    = range_low;
                            hi_next    = range_high;
                            key_next   = threshold;
                            state_next = S_QCLAMP;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Copy the element store into level 0, one entry a cycle.
            S_COPY:
            begin
                if (copy_idx_reg < M_X)
                begin
                    copy_wv_next  = 1'b1;
                    copy_idx_next = copy_idx_reg + 1'b1;
                end
                else
                begin
                    lv_next       = LW'(1);
                    seg_next      = XW'(2);
                    start_next    = '0;
                    src_base_next = '0;
                    dst_base_next = M_S;
                    a_next        = '0;
                    mid_next      = (XW'(1) < M_X) ? XW'(1) : M_X;
                    b_next        = (XW'(1) < M_X) ? XW'(1) : M_X;
                    seg_end_next  = (XW'(2) < M_X) ? XW'(2) : M_X;
                    wpos_next     = '0;
                    state_next    = S_MREAD;
                end
            end

            S_MREAD:
            begin
                state_next = S_MWRITE;
            end

            S_MWRITE:
            begin
                lm_we     = 1'b1;
                lm_waddr  = SAW'(dst_base_reg + SAW'(wpos_reg));
                lm_wdata  = take_a ? lm_rdata_a : lm_rdata_b;
                a_next    = a_adv;
                b_next    = b_adv;
                wpos_next = wpos_reg + 1'b1;
                state_next = S_MREAD;
                if (a_adv == mid_reg && b_adv == seg_end_reg)
                begin
                    if (next_start >= M_X)
                    begin
                        if (lv_reg == LV_TOP)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // Next level: segments twice as long, starting over at zero.
                            lv_next       = lv_reg + 1'b1;
                            seg_next      = seg_reg << 1;
                            half          = seg_reg;
                            start_next    = '0;
                            src_base_next = dst_base_reg;
                            dst_base_next = dst_base_reg + M_S;
                            mid_c         = (half < M_X) ? half : M_X;
                            seg_end_c     = ((seg_reg << 1) < M_X) ? (seg_reg << 1) : M_X;
                            a_next        = '0;
                            mid_next      = mid_c;
                            b_next        = mid_c;
                            seg_end_next  = seg_end_c;
                            wpos_next     = '0;
                        end
                    end
                    else
                    begin
                        half         = seg_reg >> 1;
                        mid_c        = ((next_start + half) < M_X) ? next_start + half : M_X;
                        seg_end_c    = ((next_start + seg_reg) < M_X)
                                       ? next_start + seg_reg : M_X;
                        start_next   = next_start;
                        a_next       = next_start;
                        mid_next     = mid_c;
                        b_next       = mid_c;
                        seg_end_next = seg_end_c;
                        wpos_next    = next_start;
                    end
                end
            end

            S_QCLAMP:
            begin
                total_next = '0;
                if (XW'(lo_reg) >= endv)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = XW'(lo_reg);
                    end_next   = endv;
                    lv_next    = '0;
                    base_next  = '0;
                    state_next = S_QPICK;
                end
            end

            // Grow the segment one level a cycle while it stays aligned and in range.
            S_QPICK:
            begin
                if (lv_reg != LV_TOP && (pos_reg & (s2 - 1'b1)) == '0
                    && (pos_reg + s2) <= end_reg)
                begin
                    lv_next   = lv_reg + 1'b1;
                    base_next = base_reg + M_S;
                end
                else
                begin
                    blo_next   = '0;
                    bhi_next   = len;
                    state_next = S_QREAD;
                end
            end

            S_QREAD:
            begin
                lm_raddr_a = SAW'(base_reg + SAW'(pos_reg) + SAW'(qmid));
                if (blo_reg < bhi_reg)
                begin
                    bmid_next  = qmid;
                    state_next = S_QCMP;
                end
                else
                begin
                    total_next = total_reg + (len - blo_reg);
                    pos_next   = pos_reg + len;
                    lv_next    = '0;
                    base_next  = '0;
                    state_next = ((pos_reg + len) >= end_reg) ? S_DONE : S_QPICK;
                end
            end

            S_QCMP:
            begin
                if ($signed(lm_rdata_a) < $signed(key_reg))
                begin
                    blo_next = bmid_reg + 1'b1;
                end
                else
                begin
                    bhi_next = bmid_reg;
                end
                state_next = S_QREAD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    count_next     = COUNT_W'(total_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            elem_count_reg <= ELEM_COUNT_RESET;
            lv_reg         <= '0;
            base_reg       <= '0;
            src_base_reg   <= '0;
            dst_base_reg   <= '0;
            pos_reg        <= '0;
            end_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            mid_reg        <= '0;
            seg_end_reg    <= '0;
            start_reg      <= '0;
            seg_reg        <= '0;
            wpos_reg       <= '0;
            blo_reg        <= '0;
            bhi_reg        <= '0;
            bmid_reg       <= '0;
            total_reg      <= '0;
            copy_idx_reg   <= '0;
            copy_wv_reg    <= 1'b0;
            copy_wa_reg    <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            key_reg        <= '0;
            out_valid_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            elem_count_reg <= elem_count_next;
            lv_reg         <= lv_next;
            base_reg       <= base_next;
            src_base_reg   <= src_base_next;
            dst_base_reg   <= dst_base_next;
            pos_reg        <= pos_next;
            end_reg        <= end_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            mid_reg        <= mid_next;
            seg_end_reg    <= seg_end_next;
            start_reg      <= start_next;
            seg_reg        <= seg_next;
            wpos_reg       <= wpos_next;
            blo_reg        <= blo_next;
            bhi_reg        <= bhi_next;
            bmid_reg       <= bmid_next;
            total_reg      <= total_next;
            copy_idx_reg   <= copy_idx_next;
            copy_wv_reg    <= copy_wv_next;
            copy_wa_reg    <= copy_wa_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            key_reg        <= key_next;
            out_valid_reg  <= out_valid_next;
            count_reg      <= count_next;
        end
    end

endmodule
